// File: design/xs128_pkg.sv
package xs128_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NumWords = 4;
	localparam int unsigned IdxW = $clog2(NumWords);

	typedef logic [WordW-1:0] word_t;
	typedef logic [IdxW-1:0] idx_t;

	// Action codes carried by a request
	localparam logic ACT_GENERATE = 1'b0;
	localparam logic ACT_RESEED   = 1'b1;

	// Seed expansion multiplier
	localparam word_t SEED_MUL = 32'd1812433253;

	// Per-word masks applied after each expansion round, oldest first
	localparam word_t SEED_KEY [NumWords] = '{
		32'd123464980, 32'd3447902351, 32'd2859490775, 32'd47621719
	};

	// State after reset, oldest first
	localparam word_t RESET_WORD [NumWords] = '{
		32'd123456789, 32'd362436069, 32'd521288629, 32'd88675123
	};

	// Shift amounts
	localparam int unsigned GEN_SHL_OLD = 11;
	localparam int unsigned GEN_SHR_T   = 8;
	localparam int unsigned GEN_SHR_NEW = 19;
	localparam int unsigned MIX_SHL     = 13;
	localparam int unsigned MIX_SHR     = 17;

	// Reseed sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_MIX
	} seq_state_t;

	// Controls from the sequencer to the datapath
	typedef struct packed {
		logic busy;     // reseed in progress
		logic mul_en;   // load the product register
		logic mix_en;   // take the mixed value, write one state word
		idx_t word_idx; // state word being written
	} seq_ctrl_t;

endpackage

// File: design/xorshift128_generator.sv
// xorshift128 random word generator. A generate request (action 0) steps the
// four state words once and places the new newest word in the output register,
// and the next request is taken in the following cycle as long as that register
// is free or being emptied. A reseed request (action 1) returns nothing and keeps
// the block busy while one shared seed-round unit (a registered 32x32 multiply
// followed by add and xorshift) runs a multiply state and a mix state for each
// of the four state words in turn; in the practically unreachable case that all
// four words come out zero, the expansion runs again.
// After reset the state holds the standard xorshift128 initial words.
module xorshift128_generator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    action,
	input  xs128_pkg::word_t        seed_value,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output xs128_pkg::word_t        random_word
);
	import xs128_pkg::*;

	word_t     words_q [NumWords];
	word_t     seed_q;
	word_t     rsp_word_q;
	logic      rsp_valid_q;
	word_t     mixed;
	word_t     key_word;
	word_t     gen_t;
	word_t     gen_new;
	logic      req_fire;
	logic      gen_fire;
	logic      seed_fire;
	logic      all_zero;
	seq_ctrl_t ctrl;

	assign req_ready = !ctrl.busy && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign gen_fire  = req_fire && (action == ACT_GENERATE);
	assign seed_fire = req_fire && (action == ACT_RESEED);

	// One xorshift128 step
	always_comb begin
		gen_t   = words_q[0] ^ (words_q[0] << GEN_SHL_OLD);
		gen_new = words_q[NumWords-1] ^ (words_q[NumWords-1] >> GEN_SHR_NEW)
			^ gen_t ^ (gen_t >> GEN_SHR_T);
	end

	// Masked round value for the word being written; zero test on the last word
	assign key_word = SEED_KEY[ctrl.word_idx] ^ mixed;
	assign all_zero = (words_q[0] == '0) && (words_q[1] == '0)
		&& (words_q[2] == '0) && (key_word == '0);

	xs128_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (seed_fire),
		.all_zero (all_zero),
		.ctrl     (ctrl)
	);

	xs128_seed_unit u_seed_unit (
		.clk    (clk),
		.mul_en (ctrl.mul_en),
		.seed   (seed_q),
		.mixed  (mixed)
	);

	// Running seed value
	always_ff @(posedge clk) begin
		if (seed_fire) begin
			seed_q <= seed_value;
		end else if (ctrl.mix_en) begin
			seed_q <= mixed;
		end
	end

	// State words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) begin
				words_q[i] <= RESET_WORD[i];
			end
		end else if (gen_fire) begin
			for (int i = 0; i < NumWords - 1; i++) begin
				words_q[i] <= words_q[i+1];
			end
			words_q[NumWords-1] <= gen_new;
		end else if (ctrl.mix_en) begin
			words_q[ctrl.word_idx] <= key_word;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (gen_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			rsp_word_q <= gen_new;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign random_word = rsp_word_q;

endmodule

// File: design/xs128_seed_unit.sv
module xs128_seed_unit (
	input  logic               clk,
	input  logic               mul_en,
	input  xs128_pkg::word_t   seed,
	output xs128_pkg::word_t   mixed
);
	import xs128_pkg::*;

	word_t prod_s1;
	word_t inc;
	word_t sh1;

	// Stage 1: low half of seed * multiplier
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= seed * SEED_MUL;
		end
	end

	// Stage 2: add one, then xorshift left and right
	always_comb begin
		inc   = prod_s1 + word_t'(1);
		sh1   = inc ^ (inc << MIX_SHL);
		mixed = sh1 ^ (sh1 >> MIX_SHR);
	end

endmodule

// File: design/xs128_seq.sv
module xs128_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  all_zero,
	output xs128_pkg::seq_ctrl_t  ctrl
);
	import xs128_pkg::*;

	seq_state_t state_q;
	seq_state_t state_d;
	idx_t       idx_q;
	idx_t       idx_d;
	logic       last_word;

	assign last_word = (idx_q == idx_t'(NumWords - 1));

	// State and word counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Next state and controls
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		ctrl.busy     = 1'b1;
		ctrl.mul_en   = 1'b0;
		ctrl.mix_en   = 1'b0;
		ctrl.word_idx = idx_q;
		unique case (state_q)
			SEQ_IDLE: begin
				ctrl.busy = 1'b0;
				if (start) begin
					state_d = SEQ_MUL;
					idx_d   = '0;
				end
			end
			SEQ_MUL: begin
				ctrl.mul_en = 1'b1;
				state_d     = SEQ_MIX;
			end
			SEQ_MIX: begin
				ctrl.mix_en = 1'b1;
				idx_d       = idx_q + idx_t'(1);
				// after the newest word: done unless all four words came out zero
				if (last_word && !all_zero) begin
					state_d = SEQ_IDLE;
				end else begin
					state_d = SEQ_MUL;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

endmodule

// File: design/xs128_checker.sv
module xs128_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                action,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input xs128_pkg::word_t    random_word
);
	import xs128_pkg::*;

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(random_word))
		else $error("stalled result changed or dropped");

	// A generate request yields a result in the next cycle
	a_gen_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (action == ACT_GENERATE) |=> rsp_valid)
		else $error("generate request gave no result");

	// A reseed request makes no result
	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (action == ACT_RESEED) && !rsp_valid |=> !rsp_valid)
		else $error("reseed request produced a result");

	// Busy while expanding a seed
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (action == ACT_RESEED) |=> !req_ready)
		else $error("request taken during seed expansion");

endmodule

bind xorshift128_generator xs128_checker u_xs128_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.action      (action),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.random_word (random_word)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import xs128_pkg::*;

	// Mirror of the generator state plus the words still owed by the block
	class word_scoreboard;
		word_t state_w [NumWords];
		word_t owed_words [$];
		int unsigned fail_count;

		function new();
			foreach (state_w[i]) state_w[i] = RESET_WORD[i];
			fail_count = 0;
		endfunction

		// one expansion round: multiply-add then xorshift
		function word_t seed_round(word_t s);
			word_t m;
			m = s * SEED_MUL + 32'd1;
			m = m ^ (m << MIX_SHL);
			m = m ^ (m >> MIX_SHR);
			return m;
		endfunction

		// spread the seed over all four words, again while all come out zero
		function void expand_seed(word_t s);
			do begin
				foreach (state_w[i]) begin
					s = seed_round(s);
					state_w[i] = SEED_KEY[i] ^ s;
				end
			end while (state_w[0] == '0 && state_w[1] == '0 &&
				state_w[2] == '0 && state_w[3] == '0);
		endfunction

		// one xorshift128 step, returns the new newest word
		function word_t step_xorshift();
			word_t t;
			word_t nw;
			t = state_w[0] ^ (state_w[0] << GEN_SHL_OLD);
			nw = state_w[3] ^ (state_w[3] >> GEN_SHR_NEW) ^ t ^ (t >> GEN_SHR_T);
			state_w[0] = state_w[1];
			state_w[1] = state_w[2];
			state_w[2] = state_w[3];
			state_w[3] = nw;
			return nw;
		endfunction

		function void note_request(logic act, word_t seed);
			if (act == ACT_RESEED) begin
				expand_seed(seed);
			end else begin
				owed_words.push_back(step_xorshift());
			end
		endfunction

		task report(string msg);
			$display("%0t MISMATCH: %s", $realtime, msg);
			fail_count++;
		endtask

		task check_word(word_t got);
			word_t want;
			if (owed_words.size() == 0) begin
				report($sformatf("word %h arrived with none owed", got));
			end else begin
				want = owed_words.pop_front();
				if (got !== want)
					report($sformatf("random_word %h, predicted %h", got, want));
			end
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	logic  action = ACT_GENERATE;
	word_t seed_value = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	word_t random_word;

	int unsigned send_gap_pct = 6;
	int unsigned rsp_stall_pct = 74;

	word_scoreboard board = new();

	xorshift128_generator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.seed_value  (seed_value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.random_word (random_word)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random back-pressure and checking
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			board.check_word(random_word);
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// one request, with an optional idle gap ahead of it
	task send_request(logic act, word_t seed);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		seed_value <= seed;
		do @(posedge clk); while (!req_ready);
		board.note_request(act, seed);
	endtask

	// mostly generate; reseeds now and then, some with edge-case seeds
	task send_random_request();
		word_t seed;
		int unsigned pick;
		seed = $urandom;
		pick = $urandom_range(3);
		if ($urandom_range(99) < 12) begin
			if ($urandom_range(3) == 0) begin
				case (pick)
					0: seed = '0;
					1: seed = '1;
					2: seed = word_t'(1) << $urandom_range(WordW-1);
					default: seed = ~(word_t'(1) << $urandom_range(WordW-1));
				endcase
			end
			send_request(ACT_RESEED, seed);
		end else begin
			send_request(ACT_GENERATE, seed);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, extreme seeds, back-to-back reseeds
		repeat (3) send_request(ACT_GENERATE, '0);
		send_request(ACT_GENERATE, '1);
		send_request(ACT_RESEED, '0);
		repeat (3) send_request(ACT_GENERATE, '0);
		send_request(ACT_RESEED, '1);
		repeat (2) send_request(ACT_GENERATE, 32'h5555_5555);
		send_request(ACT_RESEED, 32'h8000_0000);
		send_request(ACT_GENERATE, '0);
		send_request(ACT_RESEED, 32'd1);
		send_request(ACT_RESEED, 32'h1234_5678);
		repeat (2) send_request(ACT_GENERATE, '0);
		send_request(ACT_RESEED, 32'h5555_5555);
		send_request(ACT_RESEED, 32'hAAAA_AAAA);
		send_request(ACT_GENERATE, 32'hAAAA_AAAA);

		// random: sender sparse gaps, receiver heavy stalls
		repeat (216) send_random_request();
		// then the other way round
		send_gap_pct = 74;
		rsp_stall_pct = 6;
		repeat (216) send_random_request();
		// then full rate on both sides
		send_gap_pct = 0;
		rsp_stall_pct = 0;
		repeat (218) send_random_request();
		req_valid <= 1'b0;

		// drain, then wait on for any stray results
		while (board.owed_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: files.f
design/xs128_pkg.sv
design/xs128_seed_unit.sv
design/xs128_seq.sv
design/xorshift128_generator.sv
design/xs128_checker.sv
sim/tb_top.sv
